// ===== src/swm_pkg.sv =====
// swm_pkg: shared widths and register indexes for the sliding window mask cell
// no dependencies; imported by swm_mod_unit and sliding_window_mask_cell
package swm_pkg;

  // field and register widths
  localparam int PastW   = 13;
  localparam int RowsW   = 11;
  localparam int StoredW = 32;
  localparam int WinW    = 16;
  localparam int WrapW   = 12;
  localparam int RowW    = 10;
  localparam int ColW    = 13;
  localparam int IdxW    = 3;

  // signed width of the position distance in the datapath
  localparam int DistW   = 17;

  // configuration register indexes
  localparam logic [IdxW-1:0] REG_PAST_COLS       = 3'd0;
  localparam logic [IdxW-1:0] REG_CHUNK_ROWS      = 3'd1;
  localparam logic [IdxW-1:0] REG_REAL_NEW_TOKENS = 3'd2;
  localparam logic [IdxW-1:0] REG_STORED_TOKENS   = 3'd3;
  localparam logic [IdxW-1:0] REG_WIN_LEN         = 3'd4;

  // remainder unit request and status
  typedef struct packed {
    logic                 start;
    logic [StoredW-1:0]   dividend;
    logic [PastW-1:0]     divisor;
  } swm_mod_req_t;

  typedef struct packed {
    logic                 busy;
    logic [WrapW-1:0]     remainder;
  } swm_mod_stat_t;

endpackage

// ===== src/swm_mod_unit.sv =====
// swm_mod_unit: bit-serial restoring remainder, stored_tokens mod past width
// depends on swm_pkg for widths and the request/status structs
module swm_mod_unit
  import swm_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  swm_mod_req_t  req,
  output swm_mod_stat_t stat
);

  typedef enum logic [1:0] {
    MOD_IDLE = 2'b01,
    MOD_RUN  = 2'b10
  } mod_state_t;

  localparam int CntW = $clog2(StoredW);

  mod_state_t           state_r, state_nxt;
  logic [CntW-1:0]      cnt_r;
  logic [PastW-1:0]     rem_r;
  logic [PastW-1:0]     rem_nxt;
  logic [StoredW-1:0]   dvd_r;
  logic [PastW-1:0]     dsr_r;
  logic [WrapW-1:0]     wrap_r;
  logic [PastW:0]       trial;
  logic [PastW:0]       diff;

  // one quotient bit per cycle
  always_comb begin
    trial   = {rem_r, dvd_r[StoredW-1]};
    diff    = trial - {1'b0, dsr_r};
    rem_nxt = (trial >= {1'b0, dsr_r}) ? diff[PastW-1:0] : trial[PastW-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      MOD_IDLE: if (req.start) state_nxt = MOD_RUN;
      MOD_RUN:  if (!req.start && cnt_r == CntW'(StoredW - 1)) state_nxt = MOD_IDLE;
      default:  state_nxt = MOD_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MOD_IDLE;
      cnt_r   <= '0;
      wrap_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (req.start) begin
        cnt_r <= '0;
      end else if (state_r == MOD_RUN) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CntW'(StoredW - 1)) wrap_r <= rem_nxt[WrapW-1:0];
      end
    end
  end

  // datapath, restart wins over a step
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
    end else if (state_r == MOD_RUN) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[StoredW-2:0], 1'b0};
    end
  end

  assign stat.busy      = (state_r == MOD_RUN);
  assign stat.remainder = wrap_r;

endmodule

// ===== src/sliding_window_mask_cell.sv =====
// sliding_window_mask_cell: sliding-window causal attention mask, one cell per beat
// depends on swm_pkg and swm_mod_unit
//
// Usage:
//   in_*  : one beat carries (query row, col_index) of a mask cell.
//   out_* : one beat carries attend and in_past_region for that cell, in order.
//   cfg_* : register writes (past width, chunk rows, real new tokens,
//           stored tokens, window size at indexes 0..4); cfg_ready is always
//           high, unknown indexes are dropped. Write only while no cell is in flight.
//   A write of the past width or the stored tokens starts the ring wrap-slot
//   remainder, a bit-serial unit; in_stall is high until it has finished.
//   An input beat passes the input register, two compute stages and the
//   output register. Throughput is one cell per cycle when no stall is
//   high, set by the four-stage pipeline.
//   Reset clears config to its reset values, the wrap slot to 0, and empties
//   the pipeline. When out_stall is high, the output beat holds and bubbles
//   in earlier stages still fill, so input is taken until the pipe is full.
module sliding_window_mask_cell
  import swm_pkg::*;
#(
  parameter int MAX_PAST = 4096,
  parameter int MAX_ROWS = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  // cell input
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [RowW-1:0]     in_query_row,
  input  logic [ColW-1:0]     in_col_index,
  // cell result
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_attend,
  output logic                out_in_past_region,
  // configuration
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [IdxW-1:0]     cfg_index,
  input  logic [StoredW-1:0]  cfg_data
);

  localparam logic [16:0] MaxPastL = 17'(MAX_PAST);
  localparam logic [13:0] MaxRowsL = 14'(MAX_ROWS);

  // configuration registers
  logic [PastW-1:0]   past_r;
  logic [RowsW-1:0]   rows_r;
  logic [RowsW-1:0]   real_r;
  logic [StoredW-1:0] stored_r;
  logic [WinW-1:0]    win_r;
  logic               start_r;
  logic               sat_r;

  logic               cfg_wr;
  swm_mod_req_t       mod_req;
  swm_mod_stat_t      mod_stat;
  logic               busy;

  // derived config
  logic [PastW-1:0]   pw;
  logic [RowsW-1:0]   rows;
  logic [RowsW-1:0]   real_eff;
  logic [RowsW-1:0]   pad;
  logic [WinW-1:0]    win;
  logic [WrapW-1:0]   wrap;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      past_r   <= '0;
      rows_r   <= RowsW'(1);
      real_r   <= '0;
      stored_r <= '0;
      win_r    <= WinW'(1);
      start_r  <= 1'b0;
      sat_r    <= 1'b1;
    end else begin
      start_r <= cfg_wr &&
                 (cfg_index == REG_PAST_COLS || cfg_index == REG_STORED_TOKENS);
      sat_r   <= (stored_r >= {{(StoredW-PastW){1'b0}}, pw});
      if (cfg_wr) begin
        unique case (cfg_index)
          REG_PAST_COLS:       past_r   <= cfg_data[PastW-1:0];
          REG_CHUNK_ROWS:      rows_r   <= cfg_data[RowsW-1:0];
          REG_REAL_NEW_TOKENS: real_r   <= cfg_data[RowsW-1:0];
          REG_STORED_TOKENS:   stored_r <= cfg_data;
          REG_WIN_LEN:         win_r    <= cfg_data[WinW-1:0];
          default: ;
        endcase
      end
    end
  end

  // clamps and padding
  always_comb begin
    pw       = ({4'b0, past_r} > MaxPastL) ? PastW'(MAX_PAST) : past_r;
    rows     = ({3'b0, rows_r} > MaxRowsL) ? RowsW'(MAX_ROWS) : rows_r;
    real_eff = (real_r > rows) ? rows : real_r;
    pad      = rows - real_eff;
    win      = (win_r == '0) ? WinW'(1) : win_r;
  end

  // wrap slot remainder
  assign mod_req.start    = start_r;
  assign mod_req.dividend = stored_r;
  assign mod_req.divisor  = pw;

  swm_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .stat  (mod_stat)
  );

  assign wrap = mod_stat.remainder;
  assign busy = start_r || mod_stat.busy;

  // pipeline stage registers
  logic                    a_v_r;
  logic [RowW-1:0]         a_row_r;
  logic [ColW-1:0]         a_col_r;

  logic                    b_v_r;
  logic                    b_in_past_r;
  logic                    b_row_ok_r;
  logic                    b_past_ok_r;
  logic signed [DistW-1:0] b_base_r;
  logic signed [DistW-1:0] b_coff_r;
  logic [ColW-1:0]         b_local_r;
  logic [RowW-1:0]         b_row_r;

  logic                    c_v_r;
  logic signed [DistW-1:0] c_d_r;
  logic                    c_gate_r;
  logic                    c_in_past_r;

  logic                    out_v_r;
  logic                    out_attend_r;
  logic                    out_past_r;

  logic en_a, en_b, en_c, en_o;

  // stage advance chain, a stage moves when it is empty or the next one moves
  assign en_o     = !out_v_r || !out_stall;
  assign en_c     = !c_v_r || en_o;
  assign en_b     = !b_v_r || en_c;
  assign en_a     = !a_v_r || en_b;
  assign in_stall = !en_a || busy;

  // stage a: cell capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en_a) begin
      a_v_r <= in_valid && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && in_valid) begin
      a_row_r <= in_query_row;
      a_col_r <= in_col_index;
    end
  end

  // stage a -> b: region decode and distance operands
  logic                    a_in_past;
  logic                    a_row_ok;
  logic                    a_c_lt_w;
  logic                    a_c_lt_st;
  logic signed [DistW-1:0] a_base;
  logic signed [DistW-1:0] a_coff;

  always_comb begin
    a_in_past = (a_col_r < pw);
    a_row_ok  = ({1'b0, a_row_r} < rows);
    a_c_lt_w  = (a_col_r < {1'b0, wrap});
    a_c_lt_st = (a_col_r < stored_r[PastW-1:0]);
    if (sat_r) begin
      a_base = $signed({7'b0, a_row_r}) - $signed({6'b0, pad}) + $signed({5'b0, wrap});
      a_coff = $signed({4'b0, a_col_r}) - (a_c_lt_w ? '0 : $signed({4'b0, pw}));
    end else begin
      a_base = $signed({4'b0, stored_r[PastW-1:0]}) + $signed({7'b0, a_row_r})
             - $signed({6'b0, pad});
      a_coff = $signed({4'b0, a_col_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en_b) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b && a_v_r) begin
      b_in_past_r <= a_in_past;
      b_row_ok_r  <= a_row_ok;
      b_past_ok_r <= sat_r || a_c_lt_st;
      b_base_r    <= a_base;
      b_coff_r    <= a_coff;
      b_local_r   <= a_col_r - pw;
      b_row_r     <= a_row_r;
    end
  end

  // stage b -> c: distance from the row position and chunk bounds
  logic                    b_chunk_ok;
  logic signed [DistW-1:0] b_d;

  always_comb begin
    b_chunk_ok = (b_local_r >= {2'b0, pad}) && (b_local_r < {2'b0, rows});
    if (b_in_past_r) begin
      b_d = b_base_r - b_coff_r;
    end else begin
      b_d = $signed({7'b0, b_row_r}) - $signed({4'b0, b_local_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en_c) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c && b_v_r) begin
      c_d_r       <= b_d;
      c_gate_r    <= b_row_ok_r && (b_in_past_r ? b_past_ok_r : b_chunk_ok);
      c_in_past_r <= b_in_past_r;
    end
  end

  // stage c -> out: window test
  logic c_attend;

  assign c_attend = c_gate_r && !c_d_r[DistW-1] && (c_d_r < $signed({1'b0, win}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en_o) begin
      out_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o && c_v_r) begin
      out_attend_r <= c_attend;
      out_past_r   <= c_in_past_r;
    end
  end

  assign out_valid          = out_v_r;
  assign out_attend         = out_attend_r;
  assign out_in_past_region = out_past_r;

`ifndef SYNTHESIS
  // a ring geometry write holds off new cells on the next cycle
  a_geom_write_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && (cfg_index == REG_PAST_COLS || cfg_index == REG_STORED_TOKENS)
    |=> in_stall)
    else $error("cell accepted right after a ring geometry write");

  // a full stage behind a blocked output keeps its beat
  a_stage_c_holds: assert property (@(posedge clk) disable iff (!rst_n)
    c_v_r && out_v_r && out_stall |=> c_v_r && $stable(c_d_r))
    else $error("stage c beat lost under output stall");

  // stage a keeps its cell while stage b cannot take it
  a_stage_a_holds: assert property (@(posedge clk) disable iff (!rst_n)
    a_v_r && !en_b |=> a_v_r && $stable(a_row_r) && $stable(a_col_r))
    else $error("stage a beat changed while blocked");
`endif

endmodule

// ===== tb/sv/tb_sliding_window_mask_cell.sv =====
// tb_sliding_window_mask_cell: self-checking testbench for the sliding window mask cell
// depends on swm_pkg and sliding_window_mask_cell; predicts every cell and checks results in order
`timescale 1ns / 100ps

module tb_sliding_window_mask_cell
  import swm_pkg::*;
();

  localparam int MaxPast     = 4096;
  localparam int MaxRows     = 1024;
  localparam int SettleDelay = 8;
  localparam int LongHold    = 200;
  localparam int CycleLimit  = 200000;

  // indexes that map to no register
  localparam logic [IdxW-1:0] RegSpareLow  = 3'd5;
  localparam logic [IdxW-1:0] RegSpareHigh = 3'd7;

  typedef struct packed {
    logic attend;
    logic in_past;
  } mask_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [RowW-1:0]     in_query_row = '0;
  logic [ColW-1:0]     in_col_index = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_attend;
  logic                out_in_past_region;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [IdxW-1:0]     cfg_index = '0;
  logic [StoredW-1:0]  cfg_data = '0;

  // mirrored register state
  logic [PastW-1:0]    ring_cols_q   = '0;
  logic [RowsW-1:0]    chunk_rows_q  = 11'd1;
  logic [RowsW-1:0]    new_tokens_q  = '0;
  logic [StoredW-1:0]  stored_q      = '0;
  logic [WinW-1:0]     window_q      = 16'd1;
  logic [WrapW-1:0]    wrap_slot_q   = '0;

  mask_result_t        pending_cells[$];
  int                  fail_count = 0;
  int                  cells_sent = 0;
  int                  cells_checked = 0;
  int                  settings_used = 0;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  hold_ticket = 0;
  int                  hold_seen = 0;
  int                  hold_left = 0;
  int                  cycle_count = 0;

  sliding_window_mask_cell #(
    .MAX_PAST(MaxPast),
    .MAX_ROWS(MaxRows)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_query_row(in_query_row),
    .in_col_index(in_col_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_attend(out_attend),
    .out_in_past_region(out_in_past_region),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d cells pending", cycle_count, pending_cells.size());
      $display("sliding_window_mask_cell verification failed");
      $finish;
    end
  end

  // result side back-pressure, with an occasional long hold
  always @(posedge clk) begin
    if (hold_ticket != hold_seen) begin
      hold_seen <= hold_ticket;
      hold_left <= LongHold;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // compare each result beat with the oldest pending cell
  always @(posedge clk) begin : check_results
    mask_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_cells.size() == 0) begin
        $error("result beat with no cell pending: attend %0b in_past_region %0b",
               out_attend, out_in_past_region);
        fail_count++;
      end else begin
        want = pending_cells.pop_front();
        cells_checked++;
        if (out_attend !== want.attend) begin
          $error("attend: expected %0b, got %0b", want.attend, out_attend);
          fail_count++;
        end
        if (out_in_past_region !== want.in_past) begin
          $error("in_past_region: expected %0b, got %0b", want.in_past, out_in_past_region);
          fail_count++;
        end
      end
    end
  end

  function automatic int unsigned eff_ring_cols();
    return (32'(ring_cols_q) > MaxPast) ? MaxPast : 32'(ring_cols_q);
  endfunction

  function automatic int unsigned eff_chunk_rows();
    return (32'(chunk_rows_q) > MaxRows) ? MaxRows : 32'(chunk_rows_q);
  endfunction

  // ring position of the oldest slot, held once the ring is full
  function automatic void refresh_wrap_slot();
    longint pw, st;
    pw = longint'(eff_ring_cols());
    st = longint'(stored_q);
    if (pw > 0 && st >= pw) wrap_slot_q = WrapW'(st % pw);
    else wrap_slot_q = '0;
  endfunction

  // expected mask cell for the current register state
  function automatic mask_result_t predict_cell(input logic [RowW-1:0] row,
                                                input logic [ColW-1:0] col);
    longint pw, rows, tokens, pad, win, st, r, c, pos, lo, w, a, loc_col, first;
    mask_result_t res;
    pw = longint'(eff_ring_cols());
    rows = longint'(eff_chunk_rows());
    tokens = (longint'(new_tokens_q) > rows) ? rows : longint'(new_tokens_q);
    pad = rows - tokens;
    win = (window_q == '0) ? longint'(1) : longint'(window_q);
    st = longint'(stored_q);
    r = longint'(row);
    c = longint'(col);
    res.in_past = (c < pw);
    res.attend = 1'b0;
    if (r < rows) begin
      pos = st + r - pad;
      lo = pos - win + 1;
      if (res.in_past) begin
        if (st >= pw) begin
          // saturated ring: slots below the wrap slot are the newest
          w = longint'(wrap_slot_q);
          a = (c < w) ? st - w + c : st - w + c - pw;
          res.attend = (a >= lo) && (a <= pos);
        end else if (c < st) begin
          res.attend = (c >= lo) && (c <= pos);
        end
      end else if (c - pw < rows) begin
        // chunk diagonal, clipped by padding and window
        loc_col = c - pw;
        first = (pad > r - win + 1) ? pad : r - win + 1;
        res.attend = (loc_col >= first) && (loc_col <= r);
      end
    end
    return res;
  endfunction

  // one input beat; valid stays high into the next cell unless an idle gap follows
  task automatic send_cell(input logic [RowW-1:0] row, input logic [ColW-1:0] col);
    in_valid <= 1'b1;
    in_query_row <= row;
    in_col_index <= col;
    do @(posedge clk); while (in_stall);
    pending_cells = {pending_cells, predict_cell(row, col)};
    cells_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // stop offering cells and wait for every pending result
  task automatic drain_cells();
    in_valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (SettleDelay) @(posedge clk);
  endtask

  // register write beat; valid is lowered by the caller
  task automatic cfg_write(input logic [IdxW-1:0] idx, input logic [StoredW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PAST_COLS: begin
        ring_cols_q = data[PastW-1:0];
        refresh_wrap_slot();
      end
      REG_CHUNK_ROWS:      chunk_rows_q = data[RowsW-1:0];
      REG_REAL_NEW_TOKENS: new_tokens_q = data[RowsW-1:0];
      REG_STORED_TOKENS: begin
        stored_q = data;
        refresh_wrap_slot();
      end
      REG_WIN_LEN:         window_q = data[WinW-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [PastW-1:0] pw, input logic [RowsW-1:0] rows,
                              input logic [RowsW-1:0] tokens, input logic [StoredW-1:0] stored,
                              input logic [WinW-1:0] win, input bit with_spare);
    drain_cells();
    if (with_spare)
      cfg_write(RegSpareLow + IdxW'($urandom_range(RegSpareHigh - RegSpareLow)), $urandom);
    cfg_write(REG_PAST_COLS, StoredW'(pw));
    cfg_write(REG_CHUNK_ROWS, StoredW'(rows));
    cfg_write(REG_REAL_NEW_TOKENS, StoredW'(tokens));
    cfg_write(REG_STORED_TOKENS, stored);
    cfg_write(REG_WIN_LEN, StoredW'(win));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic random_config();
    logic [PastW-1:0]   pw;
    logic [RowsW-1:0]   rows, tokens;
    logic [StoredW-1:0] stored;
    logic [WinW-1:0]    win;
    int unsigned        pw_eff;
    case ($urandom_range(9))
      0:       pw = '0;
      5, 6:    pw = PastW'($urandom_range(17, MaxPast));
      7:       pw = PastW'(MaxPast);
      8:       pw = PastW'($urandom_range(MaxPast + 1, 8191));
      default: pw = PastW'($urandom_range(1, 16));
    endcase
    pw_eff = (32'(pw) > MaxPast) ? MaxPast : 32'(pw);
    case ($urandom_range(19))
      0:       rows = '0;
      1:       rows = RowsW'(MaxRows);
      2:       rows = RowsW'($urandom_range(MaxRows + 1, 2047));
      3, 4, 5: rows = RowsW'($urandom_range(17, MaxRows));
      default: rows = RowsW'($urandom_range(1, 16));
    endcase
    tokens = ($urandom_range(9) == 0) ? RowsW'($urandom_range(2047))
                                      : RowsW'($urandom_range(32'(rows)));
    case ($urandom_range(5))
      0:       stored = '0;
      1:       stored = $urandom_range(pw_eff);
      2:       stored = pw_eff * $urandom_range(1, 50) + $urandom_range(pw_eff);
      3:       stored = 32'hFFFF_FFFF - $urandom_range(64);
      default: stored = $urandom;
    endcase
    case ($urandom_range(7))
      0:       win = '0;
      1:       win = 16'd1;
      2:       win = 16'hFFFF;
      3:       win = WinW'($urandom_range(16'hFFFF));
      default: win = WinW'($urandom_range(1, pw_eff + 20));
    endcase
    apply_config(pw, rows, tokens, stored, win, $urandom_range(4) == 0);
  endtask

  // mostly cells inside the mask, biased toward the diagonal and the ring
  task automatic send_random_cell();
    int unsigned pw, rows, row, col, pick, back;
    pw = eff_ring_cols();
    rows = eff_chunk_rows();
    pick = $urandom_range(99);
    if (pick < 20 || rows == 0) begin
      row = $urandom_range(1023);
      col = $urandom_range(8191);
    end else begin
      row = $urandom_range(rows - 1);
      if (pick < 55) begin
        col = $urandom_range(pw + rows - 1);
      end else if (pick < 80 || pw == 0) begin
        back = $urandom_range(8);
        col = pw + row + 1;
        col = (col >= back) ? col - back : 0;
      end else begin
        col = $urandom_range(pw - 1);
      end
    end
    send_cell(RowW'(row), ColW'(col));
  endtask

  task automatic test_reset_state();
    send_cell(10'd0, 13'd0);
    send_cell(10'd0, 13'd1);
    send_cell(10'h3FF, 13'h1FFF);
    drain_cells();
  endtask

  task automatic test_ring_slots();
    // ring not yet full
    apply_config(13'd8, 11'd4, 11'd4, 32'd3, 16'd16, 1'b0);
    send_cell(10'd3, 13'd2);
    send_cell(10'd3, 13'd5);
    send_cell(10'd0, 13'd11);
    send_cell(10'd3, 13'd11);
    // saturated ring with a wrap slot inside it, padded chunk
    apply_config(13'd8, 11'd4, 11'd2, 32'd21, 16'd6, 1'b0);
    send_cell(10'd3, 13'd4);
    send_cell(10'd3, 13'd5);
    send_cell(10'd0, 13'd0);
    send_cell(10'd3, 13'd11);
    // empty ring
    apply_config(13'd8, 11'd4, 11'd4, 32'd0, 16'd4, 1'b0);
    send_cell(10'd0, 13'd0);
    send_cell(10'd3, 13'd8);
    drain_cells();
  endtask

  task automatic test_clamped_registers();
    // every register at its field maximum
    apply_config(13'h1FFF, 11'h7FF, 11'h7FF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    send_cell(10'h3FF, 13'h1FFF);
    send_cell(10'h3FF, 13'd5119);
    send_cell(10'd0, 13'd4095);
    send_cell(10'h3FF, 13'd0);
    // no chunk rows, zero window
    apply_config(13'd4, 11'd0, 11'd0, 32'd10, 16'd0, 1'b0);
    send_cell(10'd0, 13'd4);
    send_cell(10'd0, 13'd0);
    // more real tokens than rows, zero window, row past the chunk
    apply_config(13'd4, 11'd3, 11'd9, 32'd10, 16'd0, 1'b0);
    send_cell(10'd2, 13'd6);
    send_cell(10'd2, 13'd5);
    send_cell(10'd0, 13'd4);
    send_cell(10'd3, 13'd5);
    // a write to an unused index leaves the registers alone
    apply_config(13'd4, 11'd3, 11'd9, 32'd10, 16'd0, 1'b1);
    send_cell(10'd2, 13'd6);
    drain_cells();
  endtask

  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) random_config();
      else if (i % 60 == 30) drain_cells();
      send_random_cell();
    end
    drain_cells();
  endtask

  // receiver holds off while cells keep coming, so the pipe fills and stalls input
  task automatic test_long_hold();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_config();
    hold_ticket++;
    repeat (40) send_random_cell();
    drain_cells();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_ring_slots();
    test_clamped_registers();
    test_random_traffic(300, 10, 74);
    test_random_traffic(300, 74, 10);
    test_random_traffic(300, 0, 0);
    test_long_hold();
    $display("%0d cells sent, %0d results checked, %0d register settings",
             cells_sent, cells_checked, settings_used);
    $display("covered ring wrap, padding, window clipping, clamped fields and back-pressure");
    if (fail_count == 0 && pending_cells.size() == 0) begin
      $display("sliding_window_mask_cell verification clean");
    end else begin
      $display("sliding_window_mask_cell verification failed");
    end
    $finish;
  end

endmodule

// ===== sliding_window_mask_cell.f =====
src/swm_pkg.sv
src/swm_mod_unit.sv
src/sliding_window_mask_cell.sv
tb/sv/tb_sliding_window_mask_cell.sv
